// File: rtl/urq_pkg.sv
// Shared types, constants and register codes for the ultrasonic range qualifier.
package urq_pkg;

    localparam int RANGE_W = 12;
    localparam int ANGLE_W = 15;
    localparam int DIST_W  = 16;
    localparam int ALPHA_W = 9;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam int TURN_COPIES_DEF = 3;

    // Wheel-sweep windows in tenths of a degree, repeated every full turn.
    localparam int WIN_POS_LO   = 500;
    localparam int WIN_POS_HI   = 2100;
    localparam int WIN_NEG_NEAR = -1500;
    localparam int WIN_NEG_FAR  = -3100;
    localparam int TURN_TENTHS  = 3600;

    localparam logic [DIST_W-1:0]  RESET_RANGE   = 16'd6400;
    localparam logic [COUNT_W-1:0] RESET_TIMEOUT = 8'd40;
    localparam logic [ALPHA_W-1:0] RESET_ALPHA   = 9'd77;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [COUNT_W-1:0] timeout;
    } t_cfg;

endpackage

// File: rtl/urq_lane.sv
// One range channel: running average, miss counter and valid flag.
module urq_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [urq_pkg::RANGE_W-1:0]   i_range,
    input  logic                          i_skip,
    input  urq_pkg::t_cfg                 i_cfg,
    output logic [urq_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_valid,
    output logic                          o_valid_next
);
    import urq_pkg::*;

    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_valid;

    logic [DIST_W-1:0]  sample16;
    logic signed [16:0] diff;
    logic signed [26:0] prod;
    logic signed [27:0] t;
    logic [DIST_W-1:0]  avg;
    logic [COUNT_W-1:0] raw_count;

    assign sample16 = {i_range, 4'd0};
    assign diff     = $signed({1'b0, sample16}) - $signed({1'b0, r_dist});
    assign prod     = $signed({1'b0, i_cfg.alpha}) * diff;
    assign t        = $signed({4'd0, r_dist, 8'd0}) + $signed({prod[26], prod});

    always_comb begin
        if (t[27]) begin
            avg = '0;
        end else if (t[26:24] != 3'd0) begin
            avg = '1;
        end else begin
            avg = t[23:8];
        end
    end

    always_comb begin
        n_dist    = r_dist;
        raw_count = r_count;
        if (i_range == '0) begin
            raw_count = (r_count == '1) ? r_count : r_count + 8'd1;
        end else if (!i_skip) begin
            raw_count = '0;
            n_dist    = avg;
        end
        // a lowered timeout also pulls stale counts down here
        n_count      = (raw_count > i_cfg.timeout) ? i_cfg.timeout : raw_count;
        o_valid_next = n_count < i_cfg.timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= RESET_RANGE;
            r_count <= RESET_TIMEOUT;
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_dist  <= n_dist;
            r_count <= n_count;
            r_valid <= o_valid_next;
        end
    end

    assign o_distance = r_dist;
    assign o_valid    = r_valid;

endmodule

// File: rtl/urq_gate.sv
// Wheel-sweep obstruction test and blocked flag for one side sensor.
module urq_gate #(
    parameter int TURN_COPIES = urq_pkg::TURN_COPIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_range_nz,
    input  logic signed [15:0]   i_angle,
    output logic                 o_skip,
    output logic                 o_blocked
);
    import urq_pkg::*;

    logic hit;
    logic r_blocked;

    always_comb begin
        int a;
        int off;
        hit = 1'b0;
        a   = int'(i_angle);
        for (int k = 0; k < TURN_COPIES; k++) begin
            off = k * TURN_TENTHS;
            if (a > 0 && a >= WIN_POS_LO + off && a <= WIN_POS_HI + off) begin
                hit = 1'b1;
            end
            if (a < 0 && a >= WIN_NEG_FAR - off && a <= WIN_NEG_NEAR - off) begin
                hit = 1'b1;
            end
        end
    end

    assign o_skip = i_range_nz && hit;

    // flag only refreshed when the sensor returned an echo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked <= 1'b0;
        end else if (i_step && i_range_nz) begin
            r_blocked <= hit;
        end
    end

    assign o_blocked = r_blocked;

endmodule

// File: rtl/ultrasonic_range_qualifier.sv
// Top level of the ultrasonic range qualifier: input stage, three lanes, result stage.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | request   | i_in_valid / o_in_ready  | three ranges, two steering angles
//  out     | result    | o_out_valid / i_out_ready| distances, valids, angles, blocked
//  cfg     | write     | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// Each request passes through the input register and then the result
// register; one request is taken every cycle while results are drained.
// The channel state registers double as the result register, so a stalled
// result holds the state and the input register fills and then stalls.
// Synchronous active-low reset restores the filter, counter and config values.
module ultrasonic_range_qualifier #(
    parameter int TURN_COPIES = urq_pkg::TURN_COPIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [urq_pkg::RANGE_W-1:0]       i_center_range_cm,
    input  logic [urq_pkg::RANGE_W-1:0]       i_left_range_cm,
    input  logic [urq_pkg::RANGE_W-1:0]       i_right_range_cm,
    input  logic signed [urq_pkg::ANGLE_W-1:0] i_left_steer_angle,
    input  logic signed [urq_pkg::ANGLE_W-1:0] i_right_steer_angle,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [urq_pkg::DIST_W-1:0]        o_front_distance,
    output logic                              o_front_valid,
    output logic [urq_pkg::DIST_W-1:0]        o_left_distance,
    output logic signed [urq_pkg::ANGLE_W-1:0] o_left_angle,
    output logic                              o_left_valid,
    output logic [urq_pkg::DIST_W-1:0]        o_right_distance,
    output logic signed [urq_pkg::ANGLE_W-1:0] o_right_angle,
    output logic                              o_right_valid,
    output logic                              o_left_blocked,
    output logic                              o_right_blocked,
    input  logic                              i_cfg_we,
    input  logic [urq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [urq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import urq_pkg::*;

    t_cfg r_cfg;

    logic                      r_in_valid;
    logic [RANGE_W-1:0]        r_in_center, r_in_left, r_in_right;
    logic signed [ANGLE_W-1:0] r_in_la, r_in_ra;
    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_left_angle, r_right_angle;

    logic               adv;
    logic               left_skip, right_skip;
    logic               left_vn, right_vn, front_vn;
    logic signed [15:0] left_test, right_test;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha   <= RESET_ALPHA;
            r_cfg.timeout <= RESET_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:   r_cfg.alpha   <= i_cfg_data;
                CFG_TIMEOUT: r_cfg.timeout <= i_cfg_data[COUNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_center <= i_center_range_cm;
            r_in_left   <= i_left_range_cm;
            r_in_right  <= i_right_range_cm;
            r_in_la     <= i_left_steer_angle;
            r_in_ra     <= i_right_steer_angle;
        end
    end

    assign left_test  = {r_in_la[ANGLE_W-1], r_in_la};
    assign right_test = -$signed({r_in_ra[ANGLE_W-1], r_in_ra});

    urq_gate #(.TURN_COPIES(TURN_COPIES)) u_gate_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_range_nz (r_in_left != '0),
        .i_angle    (left_test),
        .o_skip     (left_skip),
        .o_blocked  (o_left_blocked)
    );

    urq_gate #(.TURN_COPIES(TURN_COPIES)) u_gate_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_range_nz (r_in_right != '0),
        .i_angle    (right_test),
        .o_skip     (right_skip),
        .o_blocked  (o_right_blocked)
    );

    urq_lane u_lane_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv),
        .i_range      (r_in_center),
        .i_skip       (1'b0),
        .i_cfg        (r_cfg),
        .o_distance   (o_front_distance),
        .o_valid      (o_front_valid),
        .o_valid_next (front_vn)
    );

    urq_lane u_lane_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv),
        .i_range      (r_in_left),
        .i_skip       (left_skip),
        .i_cfg        (r_cfg),
        .o_distance   (o_left_distance),
        .o_valid      (o_left_valid),
        .o_valid_next (left_vn)
    );

    urq_lane u_lane_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv),
        .i_range      (r_in_right),
        .i_skip       (right_skip),
        .i_cfg        (r_cfg),
        .o_distance   (o_right_distance),
        .o_valid      (o_right_valid),
        .o_valid_next (right_vn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_angle  <= '0;
            r_right_angle <= '0;
        end else if (adv) begin
            if (left_vn) begin
                r_left_angle <= r_in_la;
            end
            if (right_vn) begin
                r_right_angle <= r_in_ra;
            end
        end
    end

    assign o_left_angle  = r_left_angle;
    assign o_right_angle = r_right_angle;
    assign o_out_valid   = r_out_valid;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("result register not loaded after advance");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_center) && $stable(r_in_la))
        else $error("input register lost a waiting request");

    a_front_valid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(o_front_valid) && $stable(o_front_distance))
        else $error("front channel changed without an advance");

    a_front_valid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_front_valid == $past(front_vn))
        else $error("front valid flag not loaded from its next value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

// File: tb/urq_reading_checker.sv
// Watches the ranger channels, predicts each reading set and compares it with the block's output.
module urq_reading_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [urq_pkg::RANGE_W-1:0]        i_center_range_cm,
    input  logic [urq_pkg::RANGE_W-1:0]        i_left_range_cm,
    input  logic [urq_pkg::RANGE_W-1:0]        i_right_range_cm,
    input  logic signed [urq_pkg::ANGLE_W-1:0] i_left_steer_angle,
    input  logic signed [urq_pkg::ANGLE_W-1:0] i_right_steer_angle,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [urq_pkg::DIST_W-1:0]         i_front_distance,
    input  logic                               i_front_valid,
    input  logic [urq_pkg::DIST_W-1:0]         i_left_distance,
    input  logic signed [urq_pkg::ANGLE_W-1:0] i_left_angle,
    input  logic                               i_left_valid,
    input  logic [urq_pkg::DIST_W-1:0]         i_right_distance,
    input  logic signed [urq_pkg::ANGLE_W-1:0] i_right_angle,
    input  logic                               i_right_valid,
    input  logic                               i_left_blocked,
    input  logic                               i_right_blocked,
    input  logic                               i_cfg_we,
    input  logic [urq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [urq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import urq_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0]         front_distance;
        logic                      front_valid;
        logic [DIST_W-1:0]         left_distance;
        logic signed [ANGLE_W-1:0] left_angle;
        logic                      left_valid;
        logic [DIST_W-1:0]         right_distance;
        logic signed [ANGLE_W-1:0] right_angle;
        logic                      right_valid;
        logic                      left_blocked;
        logic                      right_blocked;
    } t_reading;

    logic [ALPHA_W-1:0]        alpha   = RESET_ALPHA;
    logic [COUNT_W-1:0]        timeout = RESET_TIMEOUT;
    logic [DIST_W-1:0]         filt_q4 [3];
    logic [COUNT_W-1:0]        misses [3];
    logic                      side_blocked [2];
    logic signed [ANGLE_W-1:0] held_angle [2];
    t_reading                  expected_readings [$];
    int                        err_count  = 0;
    int                        done_count = 0;
    int                        pending_q  = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_q;
    assign o_checked = done_count;

    // Wheel-sweep windows, one copy per full turn.
    function automatic logic in_sweep(int a);
        for (int k = 0; k < TURN_COPIES_DEF; k++) begin
            if (a > 0 && a >= WIN_POS_LO + k * TURN_TENTHS && a <= WIN_POS_HI + k * TURN_TENTHS)
                return 1'b1;
            if (a < 0 && a >= WIN_NEG_FAR - k * TURN_TENTHS && a <= WIN_NEG_NEAR - k * TURN_TENTHS)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [DIST_W-1:0] smooth(logic [DIST_W-1:0] old, logic [RANGE_W-1:0] cm);
        longint acc;
        acc = longint'(old) * 256 + longint'(alpha) * (longint'(cm) * 16 - longint'(old));
        if (acc < 0)
            acc = 0;
        if (acc > longint'(65535) * 256)
            acc = longint'(65535) * 256;
        return DIST_W'(acc / 256);
    endfunction

    function automatic logic [COUNT_W-1:0] count_miss(logic [COUNT_W-1:0] m);
        return (m == '1) ? m : m + 1'b1;
    endfunction

    task automatic predict_readings(logic [RANGE_W-1:0] c_cm, logic [RANGE_W-1:0] l_cm,
                                    logic [RANGE_W-1:0] r_cm,
                                    logic signed [ANGLE_W-1:0] la,
                                    logic signed [ANGLE_W-1:0] ra);
        logic [RANGE_W-1:0] side_cm [2];
        int                 test_ang [2];
        logic               ok [3];
        t_reading           rd;
        if (c_cm != 0) begin
            misses[0]  = '0;
            filt_q4[0] = smooth(filt_q4[0], c_cm);
        end else begin
            misses[0] = count_miss(misses[0]);
        end
        side_cm[0]  = l_cm;
        side_cm[1]  = r_cm;
        test_ang[0] = int'(la);
        test_ang[1] = -int'(ra);
        for (int s = 0; s < 2; s++) begin
            if (side_cm[s] != 0) begin
                side_blocked[s] = in_sweep(test_ang[s]);
                if (!side_blocked[s]) begin
                    misses[s+1]  = '0;
                    filt_q4[s+1] = smooth(filt_q4[s+1], side_cm[s]);
                end
            end else begin
                // a missing echo counts even on an obstructed side
                misses[s+1] = count_miss(misses[s+1]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            if (misses[ch] > timeout)
                misses[ch] = timeout;
            ok[ch] = misses[ch] < timeout;
        end
        if (ok[1])
            held_angle[0] = la;
        if (ok[2])
            held_angle[1] = ra;
        rd.front_distance = filt_q4[0];
        rd.front_valid    = ok[0];
        rd.left_distance  = filt_q4[1];
        rd.left_angle     = held_angle[0];
        rd.left_valid     = ok[1];
        rd.right_distance = filt_q4[2];
        rd.right_angle    = held_angle[1];
        rd.right_valid    = ok[2];
        rd.left_blocked   = side_blocked[0];
        rd.right_blocked  = side_blocked[1];
        expected_readings.push_back(rd);
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            alpha   = RESET_ALPHA;
            timeout = RESET_TIMEOUT;
            for (int ch = 0; ch < 3; ch++) begin
                filt_q4[ch] = RESET_RANGE;
                misses[ch]  = RESET_TIMEOUT;
            end
            for (int s = 0; s < 2; s++) begin
                side_blocked[s] = 1'b0;
                held_angle[s]   = '0;
            end
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALPHA:   alpha   = i_cfg_data[ALPHA_W-1:0];
                    CFG_TIMEOUT: timeout = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_readings(i_center_range_cm, i_left_range_cm, i_right_range_cm,
                                 i_left_steer_angle, i_right_steer_angle);
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t ns: result with no request outstanding", $time);
                    err_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("front_distance", want.front_distance, i_front_distance);
                    check_field("front_valid", want.front_valid, i_front_valid);
                    check_field("left_distance", want.left_distance, i_left_distance);
                    check_field("left_angle", $signed(want.left_angle), i_left_angle);
                    check_field("left_valid", want.left_valid, i_left_valid);
                    check_field("right_distance", want.right_distance, i_right_distance);
                    check_field("right_angle", $signed(want.right_angle), i_right_angle);
                    check_field("right_valid", want.right_valid, i_right_valid);
                    check_field("left_blocked", want.left_blocked, i_left_blocked);
                    check_field("right_blocked", want.right_blocked, i_right_blocked);
                    done_count++;
                end
            end
        end
        // updated by a nonblocking assignment, so reads at an edge never race
        pending_q <= expected_readings.size();
    end

endmodule

// File: tb/ultrasonic_range_qualifier_tb.sv
// Stimulus and verdict for the ultrasonic range qualifier: ranger requests, settings, flow control.
module ultrasonic_range_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import urq_pkg::*;

    localparam int ITEMS_PER_PHASE = 220;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RUN_LIMIT_NS    = 400000;

    logic                       i_clk               = 1'b0;
    logic                       i_rst_n             = 1'b0;
    logic                       i_in_valid          = 1'b0;
    logic                       o_in_ready;
    logic [RANGE_W-1:0]         i_center_range_cm   = '0;
    logic [RANGE_W-1:0]         i_left_range_cm     = '0;
    logic [RANGE_W-1:0]         i_right_range_cm    = '0;
    logic signed [ANGLE_W-1:0]  i_left_steer_angle  = '0;
    logic signed [ANGLE_W-1:0]  i_right_steer_angle = '0;
    logic                       o_out_valid;
    logic                       i_out_ready         = 1'b0;
    logic [DIST_W-1:0]          o_front_distance;
    logic                       o_front_valid;
    logic [DIST_W-1:0]          o_left_distance;
    logic signed [ANGLE_W-1:0]  o_left_angle;
    logic                       o_left_valid;
    logic [DIST_W-1:0]          o_right_distance;
    logic signed [ANGLE_W-1:0]  o_right_angle;
    logic                       o_right_valid;
    logic                       o_left_blocked;
    logic                       o_right_blocked;
    logic                       i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx           = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data          = '0;

    int   mismatches;
    int   outstanding;
    int   checked_results;

    bit   tx_idle_on    = 1'b1;
    bit   rx_idle_on    = 1'b1;
    bit   hold_off_req  = 1'b0;
    int   hold_off_left = 0;
    int   sent_count    = 0;
    int   setting_count = 1;
    int   cur_timeout   = RESET_TIMEOUT;
    int   echo_gap [3]  = '{0, 0, 0};

    ultrasonic_range_qualifier i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_center_range_cm   (i_center_range_cm),
        .i_left_range_cm     (i_left_range_cm),
        .i_right_range_cm    (i_right_range_cm),
        .i_left_steer_angle  (i_left_steer_angle),
        .i_right_steer_angle (i_right_steer_angle),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_front_distance    (o_front_distance),
        .o_front_valid       (o_front_valid),
        .o_left_distance     (o_left_distance),
        .o_left_angle        (o_left_angle),
        .o_left_valid        (o_left_valid),
        .o_right_distance    (o_right_distance),
        .o_right_angle       (o_right_angle),
        .o_right_valid       (o_right_valid),
        .o_left_blocked      (o_left_blocked),
        .o_right_blocked     (o_right_blocked),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    urq_reading_checker u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_center_range_cm   (i_center_range_cm),
        .i_left_range_cm     (i_left_range_cm),
        .i_right_range_cm    (i_right_range_cm),
        .i_left_steer_angle  (i_left_steer_angle),
        .i_right_steer_angle (i_right_steer_angle),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_front_distance    (o_front_distance),
        .i_front_valid       (o_front_valid),
        .i_left_distance     (o_left_distance),
        .i_left_angle        (o_left_angle),
        .i_left_valid        (o_left_valid),
        .i_right_distance    (o_right_distance),
        .i_right_angle       (o_right_angle),
        .i_right_valid       (o_right_valid),
        .i_left_blocked      (o_left_blocked),
        .i_right_blocked     (o_right_blocked),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_errors            (mismatches),
        .o_pending           (outstanding),
        .o_checked           (checked_results)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: random back-pressure plus an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            i_out_ready   <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else if (hold_off_req) begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            i_out_ready   <= 1'b0;
        end else if (rx_idle_on) begin
            i_out_ready <= ($urandom_range(99) >= 30);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_range_set(logic [RANGE_W-1:0] c_cm, logic [RANGE_W-1:0] l_cm,
                                  logic [RANGE_W-1:0] r_cm,
                                  logic signed [ANGLE_W-1:0] la,
                                  logic signed [ANGLE_W-1:0] ra);
        while (tx_idle_on && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_center_range_cm   <= c_cm;
        i_left_range_cm     <= l_cm;
        i_right_range_cm    <= r_cm;
        i_left_steer_angle  <= la;
        i_right_steer_angle <= ra;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    task automatic apply_setting(int alpha, int timeout);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ALPHA;
        i_cfg_data <= CFG_DATA_W'(alpha);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TIMEOUT;
        i_cfg_data <= CFG_DATA_W'(timeout);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_timeout = timeout;
        setting_count++;
    endtask

    // Echo dropouts come in bursts of random length, some long enough to cross the timeout.
    function automatic logic [RANGE_W-1:0] next_range(int ch);
        int unsigned pick;
        if (echo_gap[ch] > 0) begin
            echo_gap[ch]--;
            return '0;
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
            echo_gap[ch] = $urandom_range(cur_timeout + 2);
            return '0;
        end
        if (pick < 14)
            return '0;
        if (pick < 22)
            return RANGE_W'($urandom_range(40, 1));
        if (pick < 25)
            return '1;
        return RANGE_W'($urandom_range(4095, 1));
    endfunction

    // Angles cluster on the sweep window bounds of every turn, plus clear and far values.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int k;
        int bound;
        int unsigned pick;
        k    = $urandom_range(TURN_COPIES_DEF - 1);
        pick = $urandom_range(99);
        if (pick < 30)
            return ANGLE_W'(int'($urandom_range(998)) - 499);
        if (pick < 70) begin
            case ($urandom_range(3))
                0:       bound = WIN_POS_LO + k * TURN_TENTHS;
                1:       bound = WIN_POS_HI + k * TURN_TENTHS;
                2:       bound = WIN_NEG_NEAR - k * TURN_TENTHS;
                default: bound = WIN_NEG_FAR - k * TURN_TENTHS;
            endcase
            bound += int'($urandom_range(2)) - 1;
            if ($urandom_range(1))
                bound = -bound;
            return ANGLE_W'(bound);
        end
        if (pick < 75)
            return ($urandom_range(1)) ? ANGLE_W'(10800) : ANGLE_W'(-10800);
        return ANGLE_W'(int'($urandom_range(21600)) - 10800);
    endfunction

    task automatic send_random_sets(int count);
        logic [RANGE_W-1:0] c_cm, l_cm, r_cm;
        for (int n = 0; n < count; n++) begin
            c_cm = next_range(0);
            l_cm = next_range(1);
            r_cm = next_range(2);
            send_range_set(c_cm, l_cm, r_cm, pick_angle(), pick_angle());
        end
    endtask

    initial begin
        int alpha_tab [NUM_PHASES] = '{77, 0, 256, 128, 1, 255, 0, 0};
        int tmo_tab   [NUM_PHASES] = '{40, 1, 255, 4, 2, 12, 0, 0};
        int a, t;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, window bounds, misses on an obstructed side.
        send_range_set(12'd4095, 12'd4095, 12'd4095, 15'sd10800, -15'sd10800);
        send_range_set(12'd1, 12'd1, 12'd1, -15'sd10800, 15'sd10800);
        send_range_set(12'd0, 12'd0, 12'd0, 15'sd0, 15'sd0);
        send_range_set(12'd100, 12'd200, 12'd300, 15'sd500, -15'sd500);
        send_range_set(12'd100, 12'd200, 12'd300, 15'sd499, -15'sd499);
        send_range_set(12'd100, 12'd200, 12'd300, 15'sd2100, -15'sd2100);
        send_range_set(12'd100, 12'd200, 12'd300, 15'sd2101, -15'sd2101);
        send_range_set(12'd100, 12'd200, 12'd300, -15'sd1500, 15'sd1500);
        send_range_set(12'd100, 12'd200, 12'd300, -15'sd1499, 15'sd1499);
        send_range_set(12'd100, 12'd200, 12'd300, -15'sd3100, 15'sd3100);
        send_range_set(12'd100, 12'd200, 12'd300, -15'sd3101, 15'sd3101);
        send_range_set(12'd640, 12'd2048, 12'd1024, 15'sd4100, -15'sd5700);
        send_range_set(12'd640, 12'd2048, 12'd1024, 15'sd9300, 15'sd8700);
        send_range_set(12'd640, 12'd2048, 12'd1024, -15'sd10300, -15'sd9300);
        send_range_set(12'd640, 12'd2048, 12'd1024, 15'sd9301, 15'sd10301);
        send_range_set(12'd0, 12'd0, 12'd0, 15'sd1000, -15'sd1000);
        send_range_set(12'd0, 12'd0, 12'd0, 15'sd1000, -15'sd1000);
        send_range_set(12'd7, 12'd2730, 12'd1365, -15'sd1, 15'sd1);
        send_range_set(12'd2730, 12'd1365, 12'd4095, 15'sd3599, -15'sd3601);
        send_range_set(12'd0, 12'd4095, 12'd0, 15'sd16, -15'sd10800);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                a = alpha_tab[ph];
                t = tmo_tab[ph];
                if (ph >= 6) begin
                    a = $urandom_range(256);
                    t = $urandom_range(255, 1);
                end
                apply_setting(a, t);
            end
            // one phase runs with no idling on either side
            tx_idle_on = (ph != 3);
            rx_idle_on = (ph != 3);
            if (ph == 0 || ph == 5)
                hold_off_req = 1'b1;
            send_random_sets(ITEMS_PER_PHASE);
        end
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d range sets over %0d register settings, %0d results compared.",
                 sent_count, setting_count, checked_results);
        $display("Summary: %0d field mismatches found.", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d requests sent, %0d results still outstanding",
                 sent_count, outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule
